[rtl/sbet_pkg.sv]
// Shared types and constants for the swept box entry time core.
`default_nettype none

package sbet_pkg;

  // Default widths of the coordinate and time fraction fields.
  localparam int COORD_BITS_DEF     = 24;
  localparam int TIME_FRAC_BITS_DEF = 16;

  // Width of the unsigned box size fields.
  localparam int SIZE_BITS = 20;

  // Quotient bits produced by each divider stage.
  localparam int BITS_PER_STAGE = 2;

  // Side flags that travel with each divider lane.
  typedef struct packed {
    logic neg;   // numerator was negative
    logic big;   // quotient is known to be at or above the saturation point
    logic skip;  // zero motion on this axis, the lane places no bound
  } lane_flags_t;

endpackage

`default_nettype wire

[rtl/swept_box_entry_time_core.sv]
// Top level of the swept box entry time core.
//
// Answers one continuous-collision query per transaction: a box moving from
// a start center to an end center against a fixed target box, both in signed
// fixed point with unsigned sizes. The result transaction carries a hit flag
// and the first-contact fraction of the path in unsigned Q1.TIME_FRAC_BITS.
// Both channels use valid/ready; each query yields exactly one result.
// Each query passes the setup, divider, saturation and output registers.
// Throughput is one query per cycle unless the receiver stalls, set by the
// pipelined dividers that resolve two quotient bits per stage across four
// lanes (entry and exit fractions on both axes).
// The pipeline advances as one unit: while the receiver stalls a held
// result, every stage holds and in_ready drops; no query is lost or repeated.
// A synchronous reset clears all valid bits; data registers are not reset.
// The block has no configuration and keeps no state between queries.
`default_nettype none

module swept_box_entry_time_core #(
  parameter int COORD_BITS     = sbet_pkg::COORD_BITS_DEF,
  parameter int TIME_FRAC_BITS = sbet_pkg::TIME_FRAC_BITS_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               in_valid,
  output logic                                    in_ready,
  input  wire logic signed [COORD_BITS-1:0]       start_x,
  input  wire logic signed [COORD_BITS-1:0]       start_y,
  input  wire logic signed [COORD_BITS-1:0]       end_x,
  input  wire logic signed [COORD_BITS-1:0]       end_y,
  input  wire logic [sbet_pkg::SIZE_BITS-1:0]     mover_width,
  input  wire logic [sbet_pkg::SIZE_BITS-1:0]     mover_height,
  input  wire logic signed [COORD_BITS-1:0]       target_x,
  input  wire logic signed [COORD_BITS-1:0]       target_y,
  input  wire logic [sbet_pkg::SIZE_BITS-1:0]     target_width,
  input  wire logic [sbet_pkg::SIZE_BITS-1:0]     target_height,
  output logic                                    out_valid,
  input  wire logic                               out_ready,
  output logic                                    hit,
  output logic [TIME_FRAC_BITS:0]                 entry_fraction
);
  import sbet_pkg::*;

  localparam int CW  = COORD_BITS;
  localparam int TF  = TIME_FRAC_BITS;
  localparam int NW  = ((CW > SIZE_BITS + 1) ? CW : SIZE_BITS + 1) + 4;
  localparam int QB  = TF + 2;
  localparam int NST = (QB + BITS_PER_STAGE - 1) / BITS_PER_STAGE;
  localparam int TW  = TF + 3;
  localparam int VL  = NST + 3;
  localparam logic signed [TW-1:0] ONE = TW'(1) <<< TF;

  logic adv;
  logic [VL-1:0] vld;

  // Whole-pipeline advance: the output register is empty or being taken.
  assign adv       = !vld[VL-1] || out_ready;
  assign in_ready  = adv;
  assign out_valid = vld[VL-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[VL-2:0], in_valid};
    end
  end

  // Setup stage: slab numerators per axis.
  logic [SIZE_BITS:0] sum_x, sum_y;
  logic [NW-1:0] pa_x, pb_x, pd_x, pa_y, pb_y, pd_y;
  lane_flags_t   pfa_x, pfb_x, pfa_y, pfb_y;
  logic          pzm_x, pzm_y;

  assign sum_x = (SIZE_BITS+1)'(mover_width) + (SIZE_BITS+1)'(target_width);
  assign sum_y = (SIZE_BITS+1)'(mover_height) + (SIZE_BITS+1)'(target_height);

  sbet_axis_prep #(.CW(CW), .NW(NW)) u_prep_x (
    .s(start_x), .e(end_x), .c(target_x), .size_sum(sum_x),
    .mag_a(pa_x), .mag_b(pb_x), .d4(pd_x),
    .flags_a(pfa_x), .flags_b(pfb_x), .zm_miss(pzm_x)
  );

  sbet_axis_prep #(.CW(CW), .NW(NW)) u_prep_y (
    .s(start_y), .e(end_y), .c(target_y), .size_sum(sum_y),
    .mag_a(pa_y), .mag_b(pb_y), .d4(pd_y),
    .flags_a(pfa_y), .flags_b(pfb_y), .zm_miss(pzm_y)
  );

  logic [NW-1:0] ra_x, rb_x, rd_x, ra_y, rb_y, rd_y;
  lane_flags_t   rfa_x, rfb_x, rfa_y, rfb_y;
  logic [1:0]    zm_p [NST+1];

  always_ff @(posedge clk) begin
    if (adv) begin
      ra_x     <= pa_x;
      rb_x     <= pb_x;
      rd_x     <= pd_x;
      ra_y     <= pa_y;
      rb_y     <= pb_y;
      rd_y     <= pd_y;
      rfa_x    <= pfa_x;
      rfb_x    <= pfb_x;
      rfa_y    <= pfa_y;
      rfb_y    <= pfb_y;
      zm_p[0]  <= {pzm_y, pzm_x};
    end
  end

  // Zero-motion miss flags ride alongside the divider stages.
  for (genvar i = 0; i < NST; i++) begin : g_zm
    always_ff @(posedge clk) begin
      if (adv) begin
        zm_p[i+1] <= zm_p[i];
      end
    end
  end

  // Four divider lanes: entry and exit on each axis.
  logic [QB-1:0] qa_x, qb_x, qa_y, qb_y;
  logic          na_x, nb_x, na_y, nb_y;
  lane_flags_t   fa_x, fb_x, fa_y, fb_y;

  sbet_div #(.NW(NW), .QB(QB)) u_div_ax (
    .clk(clk), .en(adv), .r_in(ra_x), .d4_in(rd_x), .f_in(rfa_x),
    .q_out(qa_x), .rem_nz(na_x), .f_out(fa_x)
  );
  sbet_div #(.NW(NW), .QB(QB)) u_div_bx (
    .clk(clk), .en(adv), .r_in(rb_x), .d4_in(rd_x), .f_in(rfb_x),
    .q_out(qb_x), .rem_nz(nb_x), .f_out(fb_x)
  );
  sbet_div #(.NW(NW), .QB(QB)) u_div_ay (
    .clk(clk), .en(adv), .r_in(ra_y), .d4_in(rd_y), .f_in(rfa_y),
    .q_out(qa_y), .rem_nz(na_y), .f_out(fa_y)
  );
  sbet_div #(.NW(NW), .QB(QB)) u_div_by (
    .clk(clk), .en(adv), .r_in(rb_y), .d4_in(rd_y), .f_in(rfb_y),
    .q_out(qb_y), .rem_nz(nb_y), .f_out(fb_y)
  );

  // Saturation stage.
  logic signed [TW-1:0] ta_x, tb_x, ta_y, tb_y;

  sbet_fix #(.TF(TF)) u_fix_ax (.q(qa_x), .rem_nz(na_x), .flags(fa_x), .t(ta_x));
  sbet_fix #(.TF(TF)) u_fix_bx (.q(qb_x), .rem_nz(nb_x), .flags(fb_x), .t(tb_x));
  sbet_fix #(.TF(TF)) u_fix_ay (.q(qa_y), .rem_nz(na_y), .flags(fa_y), .t(ta_y));
  sbet_fix #(.TF(TF)) u_fix_by (.q(qb_y), .rem_nz(nb_y), .flags(fb_y), .t(tb_y));

  logic signed [TW-1:0] sa_x, sb_x, sa_y, sb_y;
  logic                 skip_x, skip_y, miss_zm;

  always_ff @(posedge clk) begin
    if (adv) begin
      sa_x    <= ta_x;
      sb_x    <= tb_x;
      sa_y    <= ta_y;
      sb_y    <= tb_y;
      skip_x  <= fa_x.skip;
      skip_y  <= fa_y.skip;
      miss_zm <= |zm_p[NST];
    end
  end

  // Resolve stage: latest entry against earliest exit.
  logic signed [TW-1:0] ent, ext;
  logic                 hit_next;
  logic [TF:0]          frac_next;

  always_comb begin
    ent = '0;
    ext = ONE;
    if (!skip_x && sa_x > ent) begin
      ent = sa_x;
    end
    if (!skip_y && sa_y > ent) begin
      ent = sa_y;
    end
    if (!skip_x && sb_x < ext) begin
      ext = sb_x;
    end
    if (!skip_y && sb_y < ext) begin
      ext = sb_y;
    end
    hit_next  = !miss_zm && (ent <= ext);
    frac_next = hit_next ? ent[TF:0] : '0;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      hit            <= hit_next;
      entry_fraction <= frac_next;
    end
  end

endmodule

`default_nettype wire

[rtl/sbet_axis_prep.sv]
// Per-axis setup: slab edge numerators, motion magnitude and zero-motion test.
`default_nettype none

module sbet_axis_prep #(
  parameter int CW = 24,
  parameter int NW = 28
) (
  input  wire logic signed [CW-1:0]          s,
  input  wire logic signed [CW-1:0]          e,
  input  wire logic signed [CW-1:0]          c,
  input  wire logic [sbet_pkg::SIZE_BITS:0]  size_sum,
  output logic [NW-1:0]                      mag_a,
  output logic [NW-1:0]                      mag_b,
  output logic [NW-1:0]                      d4,
  output sbet_pkg::lane_flags_t              flags_a,
  output sbet_pkg::lane_flags_t              flags_b,
  output logic                               zm_miss
);
  import sbet_pkg::*;

  logic signed [NW-1:0] s_ext, e_ext, c_ext, sum_ext;
  logic signed [NW-1:0] s2, d2, lo2, hi2, na, nb;
  logic [NW-1:0]        dm;
  logic                 zero;

  // Doubled positions keep the half size sum exact.
  always_comb begin
    s_ext   = NW'(s);
    e_ext   = NW'(e);
    c_ext   = NW'(c);
    sum_ext = signed'(NW'(size_sum));
    s2      = s_ext <<< 1;
    d2      = (e_ext - s_ext) <<< 1;
    lo2     = (c_ext <<< 1) - sum_ext;
    hi2     = (c_ext <<< 1) + sum_ext;
    zero    = (d2 == '0);
    if (d2[NW-1]) begin
      na = s2 - hi2;
      nb = s2 - lo2;
      dm = unsigned'(-d2);
    end else begin
      na = lo2 - s2;
      nb = hi2 - s2;
      dm = unsigned'(d2);
    end
  end

  // Magnitudes and saturation pre-checks for the two lanes of this axis.
  always_comb begin
    d4           = dm << 2;
    mag_a        = na[NW-1] ? unsigned'(-na) : unsigned'(na);
    mag_b        = nb[NW-1] ? unsigned'(-nb) : unsigned'(nb);
    flags_a.neg  = na[NW-1];
    flags_a.big  = (mag_a >= d4);
    flags_a.skip = zero;
    flags_b.neg  = nb[NW-1];
    flags_b.big  = (mag_b >= d4);
    flags_b.skip = zero;
    // Zero motion misses when the start lies outside the widened slab.
    zm_miss      = zero && ((!na[NW-1] && na != '0) || nb[NW-1]);
  end

endmodule

`default_nettype wire

[rtl/sbet_div.sv]
// Pipelined restoring divider lane, two quotient bits per register stage.
`default_nettype none

module sbet_div #(
  parameter int NW = 28,
  parameter int QB = 18
) (
  input  wire logic                  clk,
  input  wire logic                  en,
  input  wire logic [NW-1:0]         r_in,
  input  wire logic [NW-1:0]         d4_in,
  input  wire sbet_pkg::lane_flags_t f_in,
  output logic [QB-1:0]              q_out,
  output logic                       rem_nz,
  output sbet_pkg::lane_flags_t      f_out
);
  import sbet_pkg::*;

  localparam int NST = (QB + BITS_PER_STAGE - 1) / BITS_PER_STAGE;

  logic [NW-1:0] r_p [NST+1];
  logic [NW-1:0] d_p [NST+1];
  logic [QB-1:0] q_p [NST+1];
  lane_flags_t   f_p [NST+1];

  assign r_p[0] = r_in;
  assign d_p[0] = d4_in;
  assign q_p[0] = '0;
  assign f_p[0] = f_in;

  for (genvar st = 0; st < NST; st++) begin : g_stage
    logic [NW-1:0] r_n;
    logic [QB-1:0] q_n;

    // Shift the partial remainder and subtract the scaled divisor when it fits.
    always_comb begin
      r_n = r_p[st];
      q_n = q_p[st];
      for (int k = 0; k < BITS_PER_STAGE; k++) begin
        if (st * BITS_PER_STAGE + k < QB) begin
          r_n = r_n << 1;
          if (r_n >= d_p[st]) begin
            r_n = r_n - d_p[st];
            q_n = {q_n[QB-2:0], 1'b1};
          end else begin
            q_n = {q_n[QB-2:0], 1'b0};
          end
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        r_p[st+1] <= r_n;
        d_p[st+1] <= d_p[st];
        q_p[st+1] <= q_n;
        f_p[st+1] <= f_p[st];
      end
    end
  end

  assign q_out  = q_p[NST];
  assign rem_nz = |r_p[NST];
  assign f_out  = f_p[NST];

endmodule

`default_nettype wire

[rtl/sbet_fix.sv]
// Signs and saturates one lane's quotient into a fraction in [-1.0, 2.0].
`default_nettype none

module sbet_fix #(
  parameter int TF = 16
) (
  input  wire logic [TF+1:0]         q,
  input  wire logic                  rem_nz,
  input  wire sbet_pkg::lane_flags_t flags,
  output logic signed [TF+2:0]       t
);
  import sbet_pkg::*;

  localparam int TW = TF + 3;
  localparam logic signed [TW-1:0] ONE = TW'(1) <<< TF;
  localparam logic signed [TW-1:0] TWO = TW'(2) <<< TF;

  logic signed [TW-1:0] qx, qc;

  // Negative numerators floor away from zero: negate the ceiling.
  // A floor quotient at or above one already saturates once rounded up.
  always_comb begin
    qx = signed'(TW'(q));
    qc = qx + signed'(TW'(rem_nz));
    if (flags.neg) begin
      if (flags.big || qx >= ONE) begin
        t = -ONE;
      end else begin
        t = -qc;
      end
    end else begin
      if (flags.big || qx > TWO) begin
        t = TWO;
      end else begin
        t = qx;
      end
    end
  end

endmodule

`default_nettype wire

[rtl/sbet_checker.sv]
// Port-level checks for the swept box entry time core, bound to the top level.
`default_nettype none

module sbet_checker #(
  parameter int TIME_FRAC_BITS = sbet_pkg::TIME_FRAC_BITS_DEF
) (
  input wire logic                    clk,
  input wire logic                    rst,
  input wire logic                    in_ready,
  input wire logic                    out_valid,
  input wire logic                    out_ready,
  input wire logic                    hit,
  input wire logic [TIME_FRAC_BITS:0] entry_fraction
);
  import sbet_pkg::*;

  localparam logic [TIME_FRAC_BITS:0] FRAC_ONE = (TIME_FRAC_BITS+1)'(1) << TIME_FRAC_BITS;

  // A stalled result transaction holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(hit) && $stable(entry_fraction))
    else $error("result changed while stalled");

  // A miss always reports a zero fraction.
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !hit |-> entry_fraction == '0)
    else $error("miss with nonzero entry fraction");

  // A hit never lies past the end of the path.
  a_hit_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && hit |-> entry_fraction <= FRAC_ONE)
    else $error("entry fraction above one");

  // The input side is open exactly when the output register can move.
  a_ready_link: assert property (@(posedge clk) disable iff (rst)
    in_ready == (!out_valid || out_ready))
    else $error("input ready does not follow output register");

  // Reset empties the pipeline.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind swept_box_entry_time_core sbet_checker #(
  .TIME_FRAC_BITS(TIME_FRAC_BITS)
) u_sbet_checker (
  .clk(clk),
  .rst(rst),
  .in_ready(in_ready),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .hit(hit),
  .entry_fraction(entry_fraction)
);

`default_nettype wire

[test/sbet_checker.sv]
// Checker for the swept box entry time core: predicts each query and compares results.
`timescale 1ns / 100ps

module sbet_scoreboard #(
  parameter int COORD_BITS     = 24,
  parameter int TIME_FRAC_BITS = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  input  logic                            in_ready,
  input  logic signed [COORD_BITS-1:0]    start_x,
  input  logic signed [COORD_BITS-1:0]    start_y,
  input  logic signed [COORD_BITS-1:0]    end_x,
  input  logic signed [COORD_BITS-1:0]    end_y,
  input  logic [sbet_pkg::SIZE_BITS-1:0]  mover_width,
  input  logic [sbet_pkg::SIZE_BITS-1:0]  mover_height,
  input  logic signed [COORD_BITS-1:0]    target_x,
  input  logic signed [COORD_BITS-1:0]    target_y,
  input  logic [sbet_pkg::SIZE_BITS-1:0]  target_width,
  input  logic [sbet_pkg::SIZE_BITS-1:0]  target_height,
  input  logic                            out_valid,
  input  logic                            out_ready,
  input  logic                            hit,
  input  logic [TIME_FRAC_BITS:0]         entry_fraction,
  output int                              fail_count,
  output int                              pending
);

  localparam longint TIME_ONE = longint'(1) << TIME_FRAC_BITS;

  typedef struct packed {
    logic                    hit;
    logic [TIME_FRAC_BITS:0] frac;
  } contact_t;

  contact_t contact_q[$];

  // Floor division for a positive divisor.
  function automatic longint floor_quot(longint n, longint d);
    if (n >= 0) return n / d;
    return -((-n + d - 1) / d);
  endfunction

  function automatic longint clamp_time(longint q);
    if (q < -TIME_ONE) return -TIME_ONE;
    if (q > 2 * TIME_ONE) return 2 * TIME_ONE;
    return q;
  endfunction

  // Narrows the entry/exit window on one axis; returns 1 on a miss.
  function automatic bit slab_miss(longint s, longint e, longint c, longint sz,
                                   inout longint t_in, inout longint t_out);
    longint lo2, hi2, s2, d2, na, nb, d, a, b;
    lo2 = 2 * c - sz;
    hi2 = 2 * c + sz;
    s2  = 2 * s;
    d2  = 2 * (e - s);
    if (d2 == 0) return (s2 < lo2) || (s2 > hi2);
    if (d2 > 0) begin
      na = lo2 - s2; nb = hi2 - s2; d = d2;
    end else begin
      na = s2 - hi2; nb = s2 - lo2; d = -d2;
    end
    a = clamp_time(floor_quot(na * TIME_ONE, d));
    b = clamp_time(floor_quot(nb * TIME_ONE, d));
    if (a > t_in) t_in = a;
    if (b < t_out) t_out = b;
    return t_in > t_out;
  endfunction

  function automatic contact_t predict_contact();
    longint t_in, t_out;
    bit miss;
    contact_t r;
    t_in  = 0;
    t_out = TIME_ONE;
    miss = slab_miss(longint'(start_x), longint'(end_x), longint'(target_x),
                     longint'(mover_width) + longint'(target_width), t_in, t_out);
    if (!miss)
      miss = slab_miss(longint'(start_y), longint'(end_y), longint'(target_y),
                       longint'(mover_height) + longint'(target_height), t_in, t_out);
    r.hit  = !miss;
    r.frac = miss ? '0 : t_in[TIME_FRAC_BITS:0];
    return r;
  endfunction

  assign pending = contact_q.size();

  // Predict on input transactions, compare on output transactions.
  always @(posedge clk) begin
    contact_t want;
    if (rst) begin
      fail_count <= 0;
    end else begin
      if (in_valid && in_ready) contact_q = {contact_q, predict_contact()};
      if (out_valid && out_ready) begin
        if (contact_q.size() == 0) begin
          if (fail_count < 10) $display("unexpected result hit=%0d frac=%0d", hit,
                                        entry_fraction);
          fail_count <= fail_count + 1;
        end else begin
          want = contact_q.pop_front();
          if (want.hit !== hit || want.frac !== entry_fraction) begin
            if (fail_count < 10)
              $display("mismatch: expected hit=%0d frac=%0d, got hit=%0d frac=%0d",
                       want.hit, want.frac, hit, entry_fraction);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end

endmodule

[test/tb.sv]
// Testbench top for the swept box entry time core: stimulus and verdict.
`timescale 1ns / 100ps

module tb;

  localparam int CB = 24;
  localparam int TB = 16;
  localparam int SB = sbet_pkg::SIZE_BITS;
  localparam int RANDOM_QUERIES = 800;
  localparam int CYCLE_LIMIT = 200000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [CB-1:0] start_x = '0, start_y = '0, end_x = '0, end_y = '0;
  logic signed [CB-1:0] target_x = '0, target_y = '0;
  logic [SB-1:0] mover_width = '0, mover_height = '0;
  logic [SB-1:0] target_width = '0, target_height = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic hit;
  logic [TB:0] entry_fraction;
  int fail_count, pending;
  int cycles = 0;

  always #1 clk = ~clk;

  swept_box_entry_time_core i_dut (.*);

  sbet_scoreboard #(.COORD_BITS(CB), .TIME_FRAC_BITS(TB)) i_checker (.*);

  // Run-length guard.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Offers one query and waits for its transaction.
  task automatic send_query(logic [CB-1:0] sx, sy, ex, ey, tx, ty,
                            logic [SB-1:0] mw, mh, tw, th);
    int gap;
    bit taken;
    gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 8);
    // With no idle gap the next transaction follows the last one directly.
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    start_x <= sx; start_y <= sy; end_x <= ex; end_y <= ey;
    target_x <= tx; target_y <= ty;
    mover_width <= mw; mover_height <= mh;
    target_width <= tw; target_height <= th;
    // Ready is settled at the falling edge ahead of the accepting edge.
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk);
      taken = in_ready;
      @(posedge clk);
    end
  endtask

  function automatic logic [CB-1:0] near_coord(logic [CB-1:0] base, int span);
    return base + CB'($signed($urandom_range(0, 2 * span)) - span);
  endfunction

  // Receiver: random stalls, one long hold-off early on.
  initial begin
    int gap;
    bit taken;
    @(negedge rst);
    repeat (30) @(posedge clk);
    out_ready <= 1'b0;
    repeat (200) @(posedge clk);
    forever begin
      gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 8);
      if (gap != 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      taken = 1'b0;
      while (!taken) begin
        @(negedge clk);
        taken = out_valid;
        @(posedge clk);
      end
    end
  end

  initial begin
    logic [CB-1:0] sx, sy, tx, ty;
    logic [SB-1:0] mw, mh, tw, th;
    int mode;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed corners: extremes, zero motion, touching edges, axis-aligned paths.
    send_query(24'h800000, 24'h800000, 24'h7fffff, 24'h7fffff, 24'd0, 24'd0,
               '1, '1, '1, '1);
    send_query(24'h7fffff, 24'h7fffff, 24'h800000, 24'h800000, 24'd0, 24'd0,
               20'd0, 20'd0, 20'd0, 20'd0);
    send_query(24'd0, 24'd0, 24'd0, 24'd0, 24'd0, 24'd0, 20'd0, 20'd0, 20'd0, 20'd0);
    send_query(24'd0, 24'd0, 24'd0, 24'd0, 24'd10, 24'd0, 20'd10, 20'd0, 20'd10, 20'd0);
    send_query(24'd0, 24'd0, 24'd0, 24'd0, 24'd11, 24'd0, 20'd10, 20'd0, 20'd10, 20'd0);
    send_query(24'd0, 24'd0, 24'd100, 24'd0, 24'd50, 24'd0, 20'd0, 20'd0, 20'd0, 20'd0);
    send_query(24'd0, 24'd0, 24'd100, 24'd0, 24'd50, 24'd1, 20'd0, 20'd0, 20'd0, 20'd0);
    send_query(24'd100, 24'd0, 24'd0, 24'd0, 24'd50, 24'd0, 20'd4, 20'd4, 20'd4, 20'd4);
    send_query(24'd0, 24'd0, 24'd0, 24'd100, 24'd0, 24'd50, 20'd8, 20'd8, 20'd8, 20'd8);
    send_query(24'd0, 24'd0, 24'd3, 24'd7, 24'd200, 24'd200, 20'd2, 20'd2, 20'd2, 20'd2);
    send_query(24'd0, 24'd0, 24'd100, 24'd100, 24'd100, 24'd100,
               20'd0, 20'd0, 20'd0, 20'd0);
    send_query(24'd0, 24'd0, 24'd100, 24'd100, 24'd101, 24'd100,
               20'd0, 20'd0, 20'd0, 20'd0);
    send_query(24'h800000, 24'd0, 24'h7fffff, 24'd0, 24'h7fffff, 24'd0,
               '1, 20'd0, '1, 20'd0);
    send_query(24'd0, 24'd0, 24'd3, 24'd0, 24'd1, 24'd0, 20'd0, 20'd0, 20'd0, 20'd0);
    send_query(24'd5, 24'd5, 24'd5, 24'd5, 24'd5, 24'd5, '1, '1, 20'd0, 20'd0);

    repeat (RANDOM_QUERIES) begin
      mode = $urandom_range(0, 9);
      tx = CB'($urandom); ty = CB'($urandom);
      mw = $urandom_range(0, 3) == 0 ? SB'($urandom) : SB'($urandom_range(0, 4000));
      mh = $urandom_range(0, 3) == 0 ? SB'($urandom) : SB'($urandom_range(0, 4000));
      tw = $urandom_range(0, 3) == 0 ? SB'($urandom) : SB'($urandom_range(0, 4000));
      th = $urandom_range(0, 3) == 0 ? SB'($urandom) : SB'($urandom_range(0, 4000));
      if (mode < 2) begin
        // Fully random, mostly misses.
        send_query(CB'($urandom), CB'($urandom), CB'($urandom), CB'($urandom), tx, ty,
                   mw, mh, tw, th);
      end else begin
        // Path crossing near the target so hits and grazes are common.
        sx = near_coord(tx, 8000); sy = near_coord(ty, 8000);
        if (mode == 2)
          send_query(sx, sy, sx, near_coord(ty, 8000), tx, ty, mw, mh, tw, th);
        else if (mode == 3)
          send_query(sx, sy, near_coord(tx, 8000), sy, tx, ty, mw, mh, tw, th);
        else
          send_query(sx, sy, near_coord(tx, 8000), near_coord(ty, 8000), tx, ty,
                     mw, mh, tw, th);
      end
    end

    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/sbet_pkg.sv
rtl/sbet_axis_prep.sv
rtl/sbet_div.sv
rtl/sbet_fix.sv
rtl/swept_box_entry_time_core.sv
rtl/sbet_checker.sv
test/sbet_checker.sv
test/tb.sv
